// ===== hw/rtl/bitmap_frame_allocator_defines.svh =====
// Assertion helpers for the frame allocator.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define BFA_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked on every rising clock edge, reset included.
`define BFA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== hw/rtl/bfa_pkg.sv =====
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared constants, codes and types of the bitmap frame allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bfa_pkg;
    localparam int NUM_FRAMES = 4096;
    localparam int FRAME_W    = 12;
    localparam int CNT_W      = 13;
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int WORD_W_DEF = 32;

    // func codes; the high bit alone selects a free
    localparam logic [FUNC_W-1:0] FUNC_ALLOC_UP = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_ALLOC_DN = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FREE     = 2'd2;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_NO_RUN = 2'd1,
        ST_ZERO   = 2'd2,
        ST_RANGE  = 2'd3
    } t_status;

    // run of frames [lo, hi) to mark free (set) or in use
    typedef struct packed {
        logic [CNT_W-1:0] lo;
        logic [CNT_W-1:0] hi;
        logic             set;
    } t_mark;
endpackage
`default_nettype wire

// ===== hw/rtl/bfa_req_if.sv =====
// ----------------------------------------------------------------------------
// bfa_req_if
// Request channel: allocate or free a run of frames.
// ----------------------------------------------------------------------------
`default_nettype none
interface bfa_req_if;
    logic                          valid;
    logic                          ready;
    logic [bfa_pkg::FUNC_W-1:0]    func;
    logic [bfa_pkg::FRAME_W-1:0]   frame_number;
    logic [bfa_pkg::CNT_W-1:0]     count;
    modport source (output valid, func, frame_number, count, input ready);
    modport sink   (input valid, func, frame_number, count, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bfa_rsp_if.sv =====
// ----------------------------------------------------------------------------
// bfa_rsp_if
// Response channel: one item per request.
// ----------------------------------------------------------------------------
`default_nettype none
interface bfa_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [bfa_pkg::FRAME_W-1:0]   base_frame;
    logic [bfa_pkg::STATUS_W-1:0]  status;
    logic [bfa_pkg::CNT_W-1:0]     free_frames;
    modport source (output valid, base_frame, status, free_frames, input ready);
    modport sink   (input valid, base_frame, status, free_frames, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bfa_cfg_if.sv =====
// ----------------------------------------------------------------------------
// bfa_cfg_if
// Configuration write channel for the frame limit.
// ----------------------------------------------------------------------------
`default_nettype none
interface bfa_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [bfa_pkg::CNT_W-1:0]   data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// Zero count, range error or count above the limit: straight from idle to the result state.
// Scan: one frame examined at a time, with a read-wait state for each map word entered (RAM read).
// Mark/free: each map word touched is read (wait state) then written, then the result state.
// Items are taken one at a time; the single map RAM port and bit scan allow no overlap.
// Reset: a synchronous clear pass writes zero to all NUM_FRAMES/WORD_W map words
// (128 by default); no item is taken until it ends. Config writes always taken.
// ----------------------------------------------------------------------------
// bitmap_frame_allocator
// First-fit frame allocator over a one-bit-per-frame free map in RAM.
// ----------------------------------------------------------------------------
`default_nettype none
`include "bitmap_frame_allocator_defines.svh"
module bitmap_frame_allocator #(
    parameter int WORD_W = bfa_pkg::WORD_W_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    bfa_req_if.sink    i_req,
    bfa_rsp_if.source  o_rsp,
    bfa_cfg_if.sink    i_cfg
);
    localparam int CNT_W     = bfa_pkg::CNT_W;
    localparam int FRAME_W   = bfa_pkg::FRAME_W;
    localparam int IDX_W     = $clog2(WORD_W);
    localparam int NUM_WORDS = bfa_pkg::NUM_FRAMES / WORD_W;
    localparam int ADDR_W    = $clog2(NUM_WORDS);
    localparam logic [CNT_W-1:0]  LIM_MAX = CNT_W'(bfa_pkg::NUM_FRAMES);
    localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_SWAIT, S_SCAN, S_MWAIT, S_MWR, S_RESP
    } t_state;

    t_state                r_state, n_state;
    logic [CNT_W-1:0]      r_limit;
    logic                  r_dn, n_dn;          // downward scan
    logic [CNT_W-1:0]      r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_lim, n_lim;        // effective limit of this scan
    logic [CNT_W-1:0]      r_pos, n_pos;        // frame under test
    logic [CNT_W-1:0]      r_run, n_run;        // current free run length
    logic [ADDR_W-1:0]     r_addr, n_addr;
    bfa_pkg::t_mark        r_mark, n_mark;
    bfa_pkg::t_status      r_status, n_status;
    logic [CNT_W-1:0]      r_free_cnt, n_free_cnt;
    logic                  r_ovalid, n_ovalid;
    logic [FRAME_W-1:0]    r_obase, n_obase;
    bfa_pkg::t_status      r_ostatus, n_ostatus;
    logic [CNT_W-1:0]      r_ofree, n_ofree;

    logic                  ram_we;
    logic [WORD_W-1:0]     ram_wdata, ram_rdata, mask_wdata;

    bfa_ram #(.WIDTH(WORD_W), .DEPTH(NUM_WORDS)) u_map (
        .i_clk   (i_clk),
        .i_addr  (r_addr),
        .i_we    (ram_we),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    bfa_mask #(.WORD_W(WORD_W), .ADDR_W(ADDR_W)) u_mask (
        .i_addr  (r_addr),
        .i_mark  (r_mark),
        .i_rdata (ram_rdata),
        .o_wdata (mask_wdata)
    );

    assign i_req.ready       = (r_state == S_IDLE);
    assign i_cfg.ready       = 1'b1;
    assign o_rsp.valid       = r_ovalid;
    assign o_rsp.base_frame  = r_obase;
    assign o_rsp.status      = r_ostatus;
    assign o_rsp.free_frames = r_ofree;

    always_comb begin
        logic [CNT_W-1:0]   eff_lim, run_n, pos_inc, pos_dec, hi_m1, base;
        logic [CNT_W:0]     sum;
        logic               bit_free;
        n_state    = r_state;
        n_dn       = r_dn;
        n_cnt      = r_cnt;
        n_lim      = r_lim;
        n_pos      = r_pos;
        n_run      = r_run;
        n_addr     = r_addr;
        n_mark     = r_mark;
        n_status   = r_status;
        n_free_cnt = r_free_cnt;
        n_ovalid   = r_ovalid && !o_rsp.ready;
        n_obase    = r_obase;
        n_ostatus  = r_ostatus;
        n_ofree    = r_ofree;
        ram_we     = 1'b0;
        ram_wdata  = mask_wdata;

        eff_lim  = (r_limit > LIM_MAX) ? LIM_MAX : r_limit;
        bit_free = ram_rdata[r_pos[IDX_W-1:0]];
        run_n    = bit_free ? r_run + 1'b1 : '0;
        pos_inc  = r_pos + 1'b1;
        pos_dec  = r_pos - 1'b1;
        hi_m1    = r_mark.hi - 1'b1;
        base     = r_dn ? r_pos : pos_inc - r_cnt;
        sum      = '0;

        case (r_state)
            S_CLR: begin
                ram_we    = 1'b1;
                ram_wdata = '0;
                n_addr    = r_addr + 1'b1;
                if (r_addr == LAST_WORD) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    n_cnt    = i_req.count;
                    n_dn     = (i_req.func == bfa_pkg::FUNC_ALLOC_DN);
                    n_run    = '0;
                    n_status = bfa_pkg::ST_OK;
                    n_mark   = '0;
                    sum      = (CNT_W+1)'(i_req.frame_number) + (CNT_W+1)'(i_req.count);
                    if (i_req.count == '0) begin
                        n_status = bfa_pkg::ST_ZERO;
                        n_state  = S_RESP;
                    end else if (i_req.func[1]) begin
                        // any func with the high bit set frees
                        if (sum > (CNT_W+1)'(bfa_pkg::NUM_FRAMES)) begin
                            n_status = bfa_pkg::ST_RANGE;
                            n_state  = S_RESP;
                        end else begin
                            n_mark.lo  = CNT_W'(i_req.frame_number);
                            n_mark.hi  = sum[CNT_W-1:0];
                            n_mark.set = 1'b1;
                            n_addr     = i_req.frame_number[FRAME_W-1:IDX_W];
                            n_state    = S_MWAIT;
                        end
                    end else if (i_req.count > eff_lim) begin
                        n_status = bfa_pkg::ST_NO_RUN;
                        n_state  = S_RESP;
                    end else begin
                        n_lim   = eff_lim;
                        n_pos   = (i_req.func == bfa_pkg::FUNC_ALLOC_DN)
                                  ? eff_lim - 1'b1 : '0;
                        n_addr  = n_pos[FRAME_W-1:IDX_W];
                        n_state = S_SWAIT;
                    end
                end
            end
            S_SWAIT: begin
                n_state = S_SCAN;
            end
            S_SCAN: begin
                n_run = run_n;
                if (run_n == r_cnt) begin
                    n_mark.lo  = base;
                    n_mark.hi  = base + r_cnt;
                    n_mark.set = 1'b0;
                    n_addr     = base[FRAME_W-1:IDX_W];
                    n_state    = S_MWAIT;
                end else if (!r_dn) begin
                    n_pos = pos_inc;
                    if (pos_inc == r_lim) begin
                        n_status = bfa_pkg::ST_NO_RUN;
                        n_state  = S_RESP;
                    end else if (pos_inc[IDX_W-1:0] == '0) begin
                        n_addr  = pos_inc[FRAME_W-1:IDX_W];
                        n_state = S_SWAIT;
                    end
                end else begin
                    n_pos = pos_dec;
                    if (r_pos == '0) begin
                        n_status = bfa_pkg::ST_NO_RUN;
                        n_state  = S_RESP;
                    end else if (r_pos[IDX_W-1:0] == '0) begin
                        n_addr  = pos_dec[FRAME_W-1:IDX_W];
                        n_state = S_SWAIT;
                    end
                end
            end
            S_MWAIT: begin
                n_state = S_MWR;
            end
            S_MWR: begin
                ram_we = 1'b1;
                if (r_addr == hi_m1[FRAME_W-1:IDX_W]) begin
                    n_state = S_RESP;
                end else begin
                    n_addr  = r_addr + 1'b1;
                    n_state = S_MWAIT;
                end
            end
            S_RESP: begin
                if (r_status == bfa_pkg::ST_OK) begin
                    if (r_mark.set) begin
                        sum        = (CNT_W+1)'(r_free_cnt) + (CNT_W+1)'(r_cnt);
                        n_free_cnt = (sum > (CNT_W+1)'(bfa_pkg::NUM_FRAMES))
                                     ? LIM_MAX : sum[CNT_W-1:0];
                    end else begin
                        n_free_cnt = (r_cnt > r_free_cnt) ? '0 : r_free_cnt - r_cnt;
                    end
                end
                if (!r_ovalid || o_rsp.ready) begin
                    n_ovalid  = 1'b1;
                    n_ostatus = r_status;
                    n_obase   = (r_status == bfa_pkg::ST_OK && !r_mark.set)
                                ? r_mark.lo[FRAME_W-1:0] : '0;
                    n_ofree   = n_free_cnt;
                    n_state   = S_IDLE;
                end else begin
                    n_free_cnt = r_free_cnt;   // commit when the result is loaded
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_addr     <= '0;
            r_limit    <= '0;
            r_free_cnt <= '0;
            r_ovalid   <= 1'b0;
            r_run      <= '0;
            r_cnt      <= '0;
            r_mark     <= '0;
        end else begin
            r_state    <= n_state;
            r_addr     <= n_addr;
            r_free_cnt <= n_free_cnt;
            r_ovalid   <= n_ovalid;
            r_run      <= n_run;
            r_cnt      <= n_cnt;
            r_mark     <= n_mark;
            if (i_cfg.valid) begin
                r_limit <= i_cfg.data;
            end
        end
        r_dn      <= n_dn;
        r_lim     <= n_lim;
        r_pos     <= n_pos;
        r_status  <= n_status;
        r_obase   <= n_obase;
        r_ostatus <= n_ostatus;
        r_ofree   <= n_ofree;
    end

    `BFA_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_free_cnt <= LIM_MAX, "free counter above frame count")
    `BFA_ASSERT(a_run_short, i_clk, i_rst_n, (r_state == S_SCAN || r_state == S_SWAIT) |-> (r_run < r_cnt), "run reached count without stop")
    `BFA_ASSERT(a_mark_addr, i_clk, i_rst_n, (r_state == S_MWAIT || r_state == S_MWR) |-> (r_addr <= ADDR_W'((r_mark.hi - 1'b1) >> IDX_W)), "mark walked past run end")
    `BFA_ASSERT(a_resp_load, i_clk, i_rst_n, ($past(r_state) == S_RESP && r_state == S_IDLE) |-> r_ovalid, "result lost on return to idle")
endmodule
`default_nettype wire

// ===== hw/rtl/bfa_ram.sv =====
// ----------------------------------------------------------------------------
// bfa_ram
// Single-port RAM, registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module bfa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic                     i_we,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
`default_nettype wire

// ===== hw/rtl/bfa_mask.sv =====
// ----------------------------------------------------------------------------
// bfa_mask
// Merges a run of frames into one map word (read-modify-write data).
// ----------------------------------------------------------------------------
`default_nettype none
module bfa_mask #(
    parameter int WORD_W = 32,
    parameter int ADDR_W = 7
) (
    input  wire logic [ADDR_W-1:0]  i_addr,
    input  wire bfa_pkg::t_mark     i_mark,
    input  wire logic [WORD_W-1:0]  i_rdata,
    output logic      [WORD_W-1:0]  o_wdata
);
    localparam int IDX_W = $clog2(WORD_W);

    always_comb begin
        logic [bfa_pkg::CNT_W-1:0] f;
        for (int j = 0; j < WORD_W; j++) begin
            f = bfa_pkg::CNT_W'({i_addr, IDX_W'(j)});
            o_wdata[j] = (f >= i_mark.lo && f < i_mark.hi) ? i_mark.set : i_rdata[j];
        end
    end
endmodule
`default_nettype wire

// ===== sim/bitmap_frame_allocator_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_frame_allocator_test
// Self-checking bench: a behavioral model of the free map and counter predicts
// each response item; directed and random requests under varying idle and stall phases.
// ----------------------------------------------------------------------------
`default_nettype none
module bitmap_frame_allocator_test;
    localparam int NUM_FRAMES = bfa_pkg::NUM_FRAMES;
    localparam int FRAME_W    = bfa_pkg::FRAME_W;
    localparam int CNT_W      = bfa_pkg::CNT_W;
    localparam int FUNC_W     = bfa_pkg::FUNC_W;

    typedef struct packed {
        logic [FRAME_W-1:0]  base_frame;
        bfa_pkg::t_status    status;
        logic [CNT_W-1:0]    free_frames;
    } t_rsp;

    localparam int WATCHDOG_LIMIT = 40000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    bfa_req_if req_ch ();
    bfa_rsp_if rsp_ch ();
    bfa_cfg_if cfg_ch ();

    bitmap_frame_allocator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source),
        .i_cfg   (cfg_ch.sink)
    );

    always #2 i_clk = ~i_clk;

    // model state
    bit         map_free [NUM_FRAMES];
    int         free_cnt;
    int         limit_reg;
    t_rsp       rsp_expected [$];

    int         err_count;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         idle_cycles;
    int         n_sent;
    int         n_ok;
    int         n_fail;

    // Advance the model by one request and queue the predicted response.
    function automatic void predict_alloc_item(logic [FUNC_W-1:0] func,
                                               logic [FRAME_W-1:0] fnum,
                                               logic [CNT_W-1:0] cnt);
        t_rsp r;
        int   lim;
        int   run;
        int   base;
        bit   found;
        r.base_frame = '0;
        r.status = bfa_pkg::ST_OK;
        base = 0;
        found = 1'b0;
        run = 0;
        if (cnt == 0) begin
            r.status = bfa_pkg::ST_ZERO;
        end else if (func[1]) begin
            if (int'(fnum) + int'(cnt) > NUM_FRAMES) begin
                r.status = bfa_pkg::ST_RANGE;
            end else begin
                for (int i = 0; i < cnt; i++) map_free[fnum + i] = 1'b1;
                free_cnt += cnt;
                if (free_cnt > NUM_FRAMES) free_cnt = NUM_FRAMES;
            end
        end else begin
            lim = (limit_reg > NUM_FRAMES) ? NUM_FRAMES : limit_reg;
            if (func == bfa_pkg::FUNC_ALLOC_UP) begin
                for (int i = 0; i < lim && !found; i++) begin
                    run = map_free[i] ? run + 1 : 0;
                    if (run == cnt) begin
                        base = i + 1 - cnt;
                        found = 1'b1;
                    end
                end
            end else begin
                for (int i = lim; i > 0 && !found; i--) begin
                    run = map_free[i-1] ? run + 1 : 0;
                    if (run == cnt) begin
                        base = i - 1;
                        found = 1'b1;
                    end
                end
            end
            if (found) begin
                for (int i = 0; i < cnt; i++) map_free[base + i] = 1'b0;
                free_cnt = (free_cnt > cnt) ? free_cnt - cnt : 0;
                r.base_frame = base[FRAME_W-1:0];
            end else begin
                r.status = bfa_pkg::ST_NO_RUN;
            end
        end
        r.free_frames = free_cnt[CNT_W-1:0];
        rsp_expected.push_back(r);
    endfunction

    // Drive one request item and hold it until taken. Valid stays high after
    // the item is taken; the next call replaces or drops it, and a drain drops it.
    task automatic send_req(logic [FUNC_W-1:0] func, logic [FRAME_W-1:0] fnum,
                            logic [CNT_W-1:0] cnt);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid <= 1'b1;
        req_ch.func <= func;
        req_ch.frame_number <= fnum;
        req_ch.count <= cnt;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        predict_alloc_item(func, fnum, cnt);
        n_sent++;
    endtask

    // Wait for every expected response, then let the block settle.
    task automatic drain_responses();
        req_ch.valid <= 1'b0;
        while (rsp_expected.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_limit(int value);
        drain_responses();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data <= value[CNT_W-1:0];
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        limit_reg = value & 'h1FFF;
    endtask

    task automatic set_phase(int send_pct, int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // Biased random request: mostly small counts, valid frees.
    task automatic send_random_req();
        logic [FUNC_W-1:0]  func;
        logic [FRAME_W-1:0] fnum;
        logic [CNT_W-1:0]   cnt;
        int                 sel;
        sel = $urandom_range(99);
        func = FUNC_W'($urandom_range(3));
        fnum = FRAME_W'($urandom);
        if (sel < 70) cnt = CNT_W'($urandom_range(1, 16));
        else if (sel < 88) cnt = CNT_W'($urandom_range(17, 300));
        else if (sel < 93) cnt = '0;
        else cnt = CNT_W'($urandom_range(0, 8191));
        // keep most frees in range
        if (func[1] && sel < 85) begin
            fnum = FRAME_W'($urandom_range(0, NUM_FRAMES - 1));
            if (int'(fnum) + int'(cnt) > NUM_FRAMES) begin
                fnum = FRAME_W'(NUM_FRAMES - int'(cnt));
            end
        end
        send_req(func, fnum, cnt);
    endtask

    task automatic test_reset_state();
        set_phase(0, 0);
        // empty map: every allocation fails, limit 0
        send_req(bfa_pkg::FUNC_ALLOC_UP, '0, 13'd1);
        send_req(bfa_pkg::FUNC_ALLOC_DN, '0, 13'd1);
        send_req(bfa_pkg::FUNC_ALLOC_UP, 12'hFFF, 13'd0);
        send_req(bfa_pkg::FUNC_FREE, '0, 13'd0);
    endtask

    task automatic test_directed();
        set_phase(0, 0);
        write_limit(NUM_FRAMES);
        send_req(bfa_pkg::FUNC_FREE, '0, 13'd4096);
        send_req(bfa_pkg::FUNC_FREE, 12'hFFF, 13'd1);        // double free saturates
        send_req(bfa_pkg::FUNC_FREE, 12'hFFF, 13'd2);        // beyond range
        send_req(bfa_pkg::FUNC_FREE, 12'd1, 13'h1FFF);       // beyond range
        send_req(bfa_pkg::FUNC_ALLOC_UP, 12'hABC, 13'd1);
        send_req(bfa_pkg::FUNC_ALLOC_DN, 12'h543, 13'd1);
        send_req(bfa_pkg::FUNC_ALLOC_UP, '0, 13'd4097);      // larger than the limit
        send_req(bfa_pkg::FUNC_ALLOC_UP, '0, 13'd100);
        send_req(bfa_pkg::FUNC_ALLOC_DN, '0, 13'd100);
        // reserved selector frees
        send_req(bfa_pkg::FUNC_FREE | bfa_pkg::FUNC_ALLOC_DN, 12'd0, 13'd1);
        send_req(bfa_pkg::FUNC_ALLOC_UP, '0, 13'd3);
        send_req(bfa_pkg::FUNC_ALLOC_DN, '0, 13'd3000);
        send_req(bfa_pkg::FUNC_ALLOC_UP, '0, 13'd2000);      // no room left
        send_req(bfa_pkg::FUNC_FREE, 12'd10, 13'd5000);
        write_limit(13'h1FFF);                               // above NUM_FRAMES clamps
        send_req(bfa_pkg::FUNC_FREE, '0, 13'd4096);
        send_req(bfa_pkg::FUNC_ALLOC_DN, '0, 13'd4096);      // whole map
        send_req(bfa_pkg::FUNC_ALLOC_DN, '0, 13'd1);
        send_req(bfa_pkg::FUNC_FREE, 12'd4000, 13'd96);
        write_limit(0);
        send_req(bfa_pkg::FUNC_ALLOC_UP, '0, 13'd1);
        write_limit(4000);
        send_req(bfa_pkg::FUNC_ALLOC_DN, '0, 13'd1);         // free frames above limit
    endtask

    task automatic test_random_phase(int n, int send_pct, int recv_pct, int lim);
        write_limit(lim);
        set_phase(send_pct, recv_pct);
        for (int i = 0; i < n; i++) begin
            send_random_req();
            if (i == n / 2) drain_responses();       // sender waits for all
        end
    endtask

    // Response checker with random back-pressure.
    always @(posedge i_clk) begin
        t_rsp got;
        t_rsp want;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                got.base_frame = rsp_ch.base_frame;
                got.status = bfa_pkg::t_status'(rsp_ch.status);
                got.free_frames = rsp_ch.free_frames;
                if (rsp_expected.size() == 0) begin
                    $error("unexpected response item");
                    err_count++;
                end else begin
                    want = rsp_expected.pop_front();
                    if (got.status == bfa_pkg::ST_OK) n_ok++;
                    else n_fail++;
                    if (got.base_frame !== want.base_frame) begin
                        $error("base_frame expected %0d got %0d",
                               want.base_frame, got.base_frame);
                        err_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        err_count++;
                    end
                    if (got.free_frames !== want.free_frames) begin
                        $error("free_frames expected %0d got %0d",
                               want.free_frames, got.free_frames);
                        err_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Watchdog: cycles with no handshake on any channel.
    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
            || (cfg_ch.valid && cfg_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        req_ch.valid = 1'b0;
        req_ch.func = '0;
        req_ch.frame_number = '0;
        req_ch.count = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.data = '0;
        rsp_ch.ready = 1'b0;
        err_count = 0;
        idle_cycles = 0;
        n_sent = 0;
        n_ok = 0;
        n_fail = 0;
        limit_reg = 0;
        free_cnt = 0;
        foreach (map_free[i]) map_free[i] = 1'b0;
        set_phase(0, 0);
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_state();
        test_directed();
        test_random_phase(450, 0, 0, NUM_FRAMES);
        test_random_phase(450, 66, 0, 2048);
        test_random_phase(450, 0, 66, 13'h1FFF);
        test_random_phase(450, 13, 13, 37);
        drain_responses();

        $display("Sent %0d request items: %0d ok, %0d error responses,", n_sent, n_ok,
                 n_fail);
        $display("over four frame limits and four idle/stall phases.");
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
`default_nettype wire
